[src/eatrm_pkg.sv]
// ----------------------------------------------------------------------------
// eatrm_pkg
// Types and constants shared by the Euler angle to rotation matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package eatrm_pkg;

    localparam int ANGLE_W = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_W = OUT_FRAC_BITS + 2;
    localparam int Q = 30;
    localparam int CORDIC_ITERS = 30;
    localparam int QW = 33;
    localparam logic signed [QW-1:0] ONE_Q = 33'sd1073741824;
    localparam logic signed [QW-1:0] CORDIC_GAIN_INV = 33'sh026DD3B6A;
    localparam logic [24:0] DEG_TO_RAD_Q = 25'd18740330;

    typedef logic signed [QW-1:0] q_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_deg;
        logic signed [ANGLE_W-1:0] pitch_deg;
        logic signed [ANGLE_W-1:0] yaw_deg;
    } in_req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_0_0;
        logic signed [OUT_W-1:0] out_0_1;
        logic signed [OUT_W-1:0] out_0_2;
        logic signed [OUT_W-1:0] out_1_0;
        logic signed [OUT_W-1:0] out_1_1;
        logic signed [OUT_W-1:0] out_1_2;
        logic signed [OUT_W-1:0] out_2_0;
        logic signed [OUT_W-1:0] out_2_1;
        logic signed [OUT_W-1:0] out_2_2;
    } out_req_t;

    typedef struct packed {
        q_t x;
        q_t y;
        q_t z;
    } cordic_lane_t;

    typedef struct packed {
        q_t cr;
        q_t sr;
        q_t cp;
        q_t sp;
        q_t cy;
        q_t sy;
    } trig_t;

    function automatic q_t atan_q(input int i);
        q_t t;
        case (i)
            0: t = 33'sh03243F6A8;
            1: t = 33'sh01DAC6705;
            2: t = 33'sh00FADBAFC;
            3: t = 33'sh007F56EA6;
            4: t = 33'sh003FEAB76;
            5: t = 33'sh001FFD55B;
            6: t = 33'sh000FFFAAA;
            7: t = 33'sh0007FFF55;
            8: t = 33'sh0003FFFEA;
            9: t = 33'sh0001FFFFD;
            27: t = 33'sd8;
            28: t = 33'sd4;
            29: t = 33'sd2;
            default: t = q_t'((64'd1 << (30 - i)) - 64'd1);
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[src/eatrm_reduce.sv]
// ----------------------------------------------------------------------------
// eatrm_reduce
// Wraps one angle into [0,360) degrees, splits off the quadrant and converts
// the remainder to Q2.30 radians. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module eatrm_reduce (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic signed [eatrm_pkg::ANGLE_W-1:0]   angle,
    output logic             [1:0]                      quad,
    output eatrm_pkg::q_t                               z
);
    import eatrm_pkg::*;

    localparam int AW = ANGLE_W + 2;
    localparam logic signed [AW-1:0] FULL = AW'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] QUART = AW'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] HALF = AW'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] QUART3 = AW'(270 << ANGLE_FRAC_BITS);
    localparam int PW = AW + 26;

    logic signed [AW-1:0] a0_reg, a1_reg;
    logic signed [AW-1:0] a0_next, a1_next, a1;
    logic        [1:0]    q_reg, q_next;
    logic signed [AW-1:0] r_reg, r_next;
    logic        [1:0]    qo_reg;
    q_t                   z_reg;
    logic signed [PW-1:0] prod;

    always_comb begin
        a0_next = AW'(angle);
        if (a0_next < 0) begin
            a0_next = a0_next + FULL;
        end
        if (a0_next < 0) begin
            a0_next = a0_next + FULL;
        end
        a1 = a0_reg;
        if (a1 >= FULL) begin
            a1 = a1 - FULL;
        end
        if (a1 >= FULL) begin
            a1 = a1 - FULL;
        end
        a1_next = a1;
        if (a1_reg >= QUART3) begin
            q_next = 2'd3;
            r_next = a1_reg - QUART3;
        end else if (a1_reg >= HALF) begin
            q_next = 2'd2;
            r_next = a1_reg - HALF;
        end else if (a1_reg >= QUART) begin
            q_next = 2'd1;
            r_next = a1_reg - QUART;
        end else begin
            q_next = 2'd0;
            r_next = a1_reg;
        end
        prod = PW'(r_reg) * PW'($signed({1'b0, DEG_TO_RAD_Q}));
        prod = (prod + (PW'(1) <<< (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg <= a0_next;
            a1_reg <= a1_next;
            q_reg  <= q_next;
            r_reg  <= r_next;
            qo_reg <= q_reg;
            z_reg  <= QW'(prod);
        end
    end

    assign quad = qo_reg;
    assign z    = z_reg;

endmodule

`default_nettype wire

[src/eatrm_cordic.sv]
// ----------------------------------------------------------------------------
// eatrm_cordic
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage,
// followed by clamping and quadrant mapping to cosine and sine.
// ----------------------------------------------------------------------------
`default_nettype none

module eatrm_cordic (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [1:0]    quad,
    input  wire eatrm_pkg::q_t z,
    output eatrm_pkg::q_t      c,
    output eatrm_pkg::q_t      s
);
    import eatrm_pkg::*;

    cordic_lane_t lane_reg [CORDIC_ITERS+1];
    logic [1:0]   quad_reg [CORDIC_ITERS+1];
    q_t           c_reg, s_reg, xc, yc;

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg[0].x <= CORDIC_GAIN_INV;
            lane_reg[0].y <= '0;
            lane_reg[0].z <= z;
            quad_reg[0]   <= quad;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        cordic_lane_t nl;
        always_comb begin
            if (!lane_reg[i].z[QW-1]) begin
                nl.x = lane_reg[i].x - (lane_reg[i].y >>> i);
                nl.y = lane_reg[i].y + (lane_reg[i].x >>> i);
                nl.z = lane_reg[i].z - atan_q(i);
            end else begin
                nl.x = lane_reg[i].x + (lane_reg[i].y >>> i);
                nl.y = lane_reg[i].y - (lane_reg[i].x >>> i);
                nl.z = lane_reg[i].z + atan_q(i);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                lane_reg[i+1] <= nl;
                quad_reg[i+1] <= quad_reg[i];
            end
        end
    end

    always_comb begin
        xc = lane_reg[CORDIC_ITERS].x;
        yc = lane_reg[CORDIC_ITERS].y;
        if (xc > ONE_Q) xc = ONE_Q;
        if (xc < -ONE_Q) xc = -ONE_Q;
        if (yc > ONE_Q) yc = ONE_Q;
        if (yc < -ONE_Q) yc = -ONE_Q;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            case (quad_reg[CORDIC_ITERS])
                2'd0: begin c_reg <= xc;  s_reg <= yc;  end
                2'd1: begin c_reg <= -yc; s_reg <= xc;  end
                2'd2: begin c_reg <= -xc; s_reg <= -yc; end
                default: begin c_reg <= yc; s_reg <= -xc; end
            endcase
        end
    end

    assign c = c_reg;
    assign s = s_reg;

endmodule

`default_nettype wire

[src/eatrm_matrix.sv]
// ----------------------------------------------------------------------------
// eatrm_matrix
// Builds the nine rotation matrix elements from the six sines and cosines in
// two multiply stages and one output rounding stage.
// ----------------------------------------------------------------------------
`default_nettype none

module eatrm_matrix (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire eatrm_pkg::trig_t                  t,
    output logic signed [eatrm_pkg::OUT_W-1:0]     m [9]
);
    import eatrm_pkg::*;

    localparam int OW = OUT_W;
    localparam int SH = Q - OUT_FRAC_BITS;

    function automatic q_t mulq(input q_t a, input q_t b);
        logic signed [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b);
        p = (p + ((2*QW)'(1) <<< (Q - 1))) >>> Q;
        return QW'(p);
    endfunction

    function automatic logic signed [OW-1:0] to_out(input q_t v);
        logic signed [QW:0] o;
        o = (QW+1)'(v);
        if (SH > 0) begin
            o = (o + ((QW+1)'(1) <<< (SH - 1))) >>> SH;
        end
        if (o > ((QW+1)'(1) <<< OUT_FRAC_BITS)) o = (QW+1)'(1) <<< OUT_FRAC_BITS;
        if (o < -((QW+1)'(1) <<< OUT_FRAC_BITS)) o = -((QW+1)'(1) <<< OUT_FRAC_BITS);
        return OW'(o);
    endfunction

    q_t cysp_reg, sysp_reg, sp_reg, cr_reg, sr_reg;
    q_t sycr_reg, sysr_reg, cycr_reg, cysr_reg;
    q_t r00_reg, r10_reg, r21_reg, r22_reg;
    q_t r00b_reg, r10b_reg, r20b_reg, r21b_reg, r22b_reg;
    q_t r01_reg, r02_reg, r11_reg, r12_reg;
    logic signed [OW-1:0] m_reg [9];

    always_ff @(posedge aclk) begin
        if (en) begin
            cysp_reg <= mulq(t.cy, t.sp);
            sysp_reg <= mulq(t.sy, t.sp);
            sycr_reg <= mulq(t.sy, t.cr);
            sysr_reg <= mulq(t.sy, t.sr);
            cycr_reg <= mulq(t.cy, t.cr);
            cysr_reg <= mulq(t.cy, t.sr);
            r00_reg  <= mulq(t.cy, t.cp);
            r10_reg  <= mulq(t.sy, t.cp);
            r21_reg  <= mulq(t.cp, t.sr);
            r22_reg  <= mulq(t.cp, t.cr);
            sp_reg   <= t.sp;
            cr_reg   <= t.cr;
            sr_reg   <= t.sr;
            r01_reg  <= mulq(cysp_reg, sr_reg) - sycr_reg;
            r02_reg  <= mulq(cysp_reg, cr_reg) + sysr_reg;
            r11_reg  <= mulq(sysp_reg, sr_reg) + cycr_reg;
            r12_reg  <= mulq(sysp_reg, cr_reg) - cysr_reg;
            r00b_reg <= r00_reg;
            r10b_reg <= r10_reg;
            r20b_reg <= -sp_reg;
            r21b_reg <= r21_reg;
            r22b_reg <= r22_reg;
            m_reg[0] <= to_out(r00b_reg);
            m_reg[1] <= to_out(r10b_reg);
            m_reg[2] <= to_out(r20b_reg);
            m_reg[3] <= to_out(r01_reg);
            m_reg[4] <= to_out(r11_reg);
            m_reg[5] <= to_out(r21b_reg);
            m_reg[6] <= to_out(r02_reg);
            m_reg[7] <= to_out(r12_reg);
            m_reg[8] <= to_out(r22b_reg);
        end
    end

    assign m = m_reg;

endmodule

`default_nettype wire

[src/euler_angles_to_rotation_matrix_unit.sv]
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_unit
// Converts roll, pitch and yaw in fixed-point degrees to the transposed
// ZYX rotation matrix in fixed point.
//
// A request on the s_ channel carries three angles; the m_ channel returns
// one request of nine matrix elements for each. The pipeline is 39 register
// stages deep: four for angle reduction, 31 for the CORDIC, one quadrant
// mapping stage and three for the products and output rounding. A new
// request enters every cycle. When the receiver stalls, the whole pipeline
// holds; s_ready is high whenever the output stage is empty or being taken,
// so nothing is lost or repeated. Reset clears every valid bit; data
// registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_angles_to_rotation_matrix_unit (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire eatrm_pkg::in_req_t       s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output eatrm_pkg::out_req_t           m_data
);
    import eatrm_pkg::*;

    localparam int DEPTH = 4 + CORDIC_ITERS + 2 + 3;
    localparam int OW = OUT_W;

    logic             en;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic [1:0]       qr, qp, qy;
    q_t               zr, zp, zy;
    q_t               cr, sr, cp, sp, cy, sy;
    trig_t            t;
    logic signed [OW-1:0] m [9];

    assign en = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;

    always_comb begin
        vld_next = en ? {vld_reg[DEPTH-2:0], s_valid} : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    eatrm_reduce u_red_r (
        .aclk(aclk), .en(en), .angle(s_data.roll_deg), .quad(qr), .z(zr));
    eatrm_reduce u_red_p (
        .aclk(aclk), .en(en), .angle(s_data.pitch_deg), .quad(qp), .z(zp));
    eatrm_reduce u_red_y (
        .aclk(aclk), .en(en), .angle(s_data.yaw_deg), .quad(qy), .z(zy));

    eatrm_cordic u_cor_r (.aclk(aclk), .en(en), .quad(qr), .z(zr), .c(cr), .s(sr));
    eatrm_cordic u_cor_p (.aclk(aclk), .en(en), .quad(qp), .z(zp), .c(cp), .s(sp));
    eatrm_cordic u_cor_y (.aclk(aclk), .en(en), .quad(qy), .z(zy), .c(cy), .s(sy));

    assign t = {cr, sr, cp, sp, cy, sy};

    eatrm_matrix u_mat (
        .aclk(aclk), .en(en), .t(t), .m(m));

    assign m_data = {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};

    assign m_valid = vld_reg[DEPTH-1];

endmodule

`default_nettype wire
